>>> rtl/core/assert_macros.svh
// Concurrent assertion shorthands.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

>>> rtl/core/bts_pkg.sv
package bts_pkg;

  localparam int TEXEL_W = 32;
  localparam int CH_W    = 8;
  localparam int N_CH    = TEXEL_W / CH_W;
  localparam int INDEX_W = 16;
  localparam int POS_W   = 20;
  localparam int REG_W   = 9;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  localparam logic [REG_W-1:0] SIZE_RESET = 9'd256;

endpackage

>>> rtl/core/bts_req_if.sv
interface bts_req_if import bts_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic [INDEX_W-1:0]        texel_index;
  logic [TEXEL_W-1:0]        texel_value;
  logic signed [POS_W-1:0]   x_pos;
  logic signed [POS_W-1:0]   y_pos;

  modport source (output valid, mode, texel_index, texel_value, x_pos, y_pos, input ready);
  modport sink   (input valid, mode, texel_index, texel_value, x_pos, y_pos, output ready);
endinterface

>>> rtl/core/bts_rsp_if.sv
interface bts_rsp_if import bts_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TEXEL_W-1:0] sampled_texel;

  modport source (output valid, sampled_texel, input ready);
  modport sink   (input valid, sampled_texel, output ready);
endinterface

>>> rtl/core/bilinear_rgba8_texel_sampler.sv
// Samples pass through the clamp, neighbor, row offset, fetch and two blend stages; stores retire in stage 4.
// Throughput: one item per cycle; each stage stalls only when full and blocked.
// Texel fetch: two copies of the store, two read ports each, give four reads a cycle.
// Reset: async, active low; clears valid bits and sets both sizes to 256
// (saturated to the maximum). Texel store is not cleared.
module bilinear_rgba8_texel_sampler import bts_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int FRAC_BITS  = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [REG_W-1:0]     cfg_wdata_i,
  bts_req_if.sink              req_i,
  bts_rsp_if.source            rsp_o
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = 2 * REG_W;
  localparam int XMW   = REG_W + FRAC_BITS;
  localparam int LW    = ((POS_W > XMW) ? POS_W : XMW) + 1;
  localparam logic [REG_W-1:0] W_RST =
    (SIZE_RESET > MAX_WIDTH) ? REG_W'(MAX_WIDTH) : SIZE_RESET;
  localparam logic [REG_W-1:0] H_RST =
    (SIZE_RESET > MAX_HEIGHT) ? REG_W'(MAX_HEIGHT) : SIZE_RESET;

  function automatic logic [REG_W-1:0] eff_size(input logic [REG_W-1:0] r,
                                                input int unsigned maxv);
    if (r == '0) return REG_W'(1);
    else if (32'(r) > maxv) return REG_W'(maxv);
    else return r;
  endfunction

  function automatic logic [CH_W-1:0] lerp(input logic [CH_W-1:0] a,
                                           input logic [CH_W-1:0] b,
                                           input logic [FRAC_BITS-1:0] f);
    logic signed [CH_W:0]             d;
    logic signed [CH_W+FRAC_BITS+1:0] p;
    d = signed'({1'b0, b}) - signed'({1'b0, a});
    p = d * signed'({1'b0, f});
    return a + CH_W'(p >>> FRAC_BITS);
  endfunction

  // effective sizes
  logic [REG_W-1:0] w_q, h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= W_RST;
      h_q <= H_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_IMAGE_WIDTH:  w_q <= eff_size(cfg_wdata_i, MAX_WIDTH);
        REG_IMAGE_HEIGHT: h_q <= eff_size(cfg_wdata_i, MAX_HEIGHT);
        default: ;
      endcase
    end
  end

  logic en1, en2, en3, en4, en5, en6;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic mode3_q;

  assign en6 = !v6_q || rsp_o.ready;
  assign en5 = !v5_q || en6;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign req_i.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (en1) v1_q <= req_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q && (mode3_q == MODE_SAMPLE);
      if (en5) v5_q <= v4_q;
      if (en6) v6_q <= v5_q;
    end
  end

  // stage 1: clamp position
  logic signed [LW-1:0] x_ext, y_ext, xmax, ymax, xc, yc;

  assign x_ext = LW'(req_i.x_pos);
  assign y_ext = LW'(req_i.y_pos);
  assign xmax  = LW'({w_q - REG_W'(1), {FRAC_BITS{1'b0}}});
  assign ymax  = LW'({h_q - REG_W'(1), {FRAC_BITS{1'b0}}});
  assign xc = (x_ext < 0) ? '0 : ((x_ext > xmax) ? xmax : x_ext);
  assign yc = (y_ext < 0) ? '0 : ((y_ext > ymax) ? ymax : y_ext);

  logic                 mode1_q, we1_q;
  logic [AW-1:0]        waddr1_q;
  logic [TEXEL_W-1:0]   wdata1_q;
  logic [REG_W-1:0]     xi1_q, yi1_q;
  logic [FRAC_BITS-1:0] fx1_q, fy1_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      mode1_q  <= req_i.mode;
      we1_q    <= 32'(req_i.texel_index) < DEPTH;
      waddr1_q <= AW'(req_i.texel_index);
      wdata1_q <= req_i.texel_value;
      xi1_q    <= xc[FRAC_BITS +: REG_W];
      yi1_q    <= yc[FRAC_BITS +: REG_W];
      fx1_q    <= xc[FRAC_BITS-1:0];
      fy1_q    <= yc[FRAC_BITS-1:0];
    end
  end

  // stage 2: right and lower neighbors
  logic [REG_W:0] xn, yn;

  assign xn = {1'b0, xi1_q} + (REG_W+1)'(1);
  assign yn = {1'b0, yi1_q} + (REG_W+1)'(1);

  logic                 mode2_q, we2_q;
  logic [AW-1:0]        waddr2_q;
  logic [TEXEL_W-1:0]   wdata2_q;
  logic [REG_W-1:0]     xi2_q, yi2_q, xj2_q, yj2_q;
  logic [FRAC_BITS-1:0] fx2_q, fy2_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      mode2_q  <= mode1_q;
      we2_q    <= we1_q;
      waddr2_q <= waddr1_q;
      wdata2_q <= wdata1_q;
      xi2_q    <= xi1_q;
      yi2_q    <= yi1_q;
      xj2_q    <= (xn < {1'b0, w_q}) ? xn[REG_W-1:0] : w_q - REG_W'(1);
      yj2_q    <= (yn < {1'b0, h_q}) ? yn[REG_W-1:0] : h_q - REG_W'(1);
      fx2_q    <= fx1_q;
      fy2_q    <= fy1_q;
    end
  end

  // stage 3: row offsets
  logic                 we3_q;
  logic [AW-1:0]        waddr3_q;
  logic [TEXEL_W-1:0]   wdata3_q;
  logic [RW-1:0]        row_a3_q, row_c3_q;
  logic [REG_W-1:0]     xi3_q, xj3_q;
  logic [FRAC_BITS-1:0] fx3_q, fy3_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      mode3_q  <= mode2_q;
      we3_q    <= we2_q;
      waddr3_q <= waddr2_q;
      wdata3_q <= wdata2_q;
      row_a3_q <= RW'(yi2_q) * RW'(w_q);
      row_c3_q <= RW'(yj2_q) * RW'(w_q);
      xi3_q    <= xi2_q;
      xj3_q    <= xj2_q;
      fx3_q    <= fx2_q;
      fy3_q    <= fy2_q;
    end
  end

  // stage 4: texel fetch, stores
  logic [AW-1:0] addr_a, addr_b, addr_c, addr_d;

  assign addr_a = AW'(row_a3_q + RW'(xi3_q));
  assign addr_b = AW'(row_a3_q + RW'(xj3_q));
  assign addr_c = AW'(row_c3_q + RW'(xi3_q));
  assign addr_d = AW'(row_c3_q + RW'(xj3_q));

  logic store_en;

  assign store_en = en4 && v3_q && (mode3_q == MODE_WRITE) && we3_q;

  logic [TEXEL_W-1:0] mem_top_q [DEPTH];
  logic [TEXEL_W-1:0] mem_bot_q [DEPTH];
  logic [TEXEL_W-1:0] ta4_q, tb4_q, tc4_q, td4_q;
  logic [FRAC_BITS-1:0] fx4_q, fy4_q;

  always_ff @(posedge clk_i) begin
    if (store_en) mem_top_q[waddr3_q] <= wdata3_q;
    if (en4) begin
      ta4_q <= mem_top_q[addr_a];
      tb4_q <= mem_top_q[addr_b];
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_en) mem_bot_q[waddr3_q] <= wdata3_q;
    if (en4) begin
      tc4_q <= mem_bot_q[addr_c];
      td4_q <= mem_bot_q[addr_d];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      fx4_q <= fx3_q;
      fy4_q <= fy3_q;
    end
  end

  // stage 5: blend along x
  logic [TEXEL_W-1:0] top_d, bot_d;

  always_comb begin
    for (int c = 0; c < N_CH; c++) begin
      top_d[c*CH_W +: CH_W] = lerp(ta4_q[c*CH_W +: CH_W], tb4_q[c*CH_W +: CH_W], fx4_q);
      bot_d[c*CH_W +: CH_W] = lerp(tc4_q[c*CH_W +: CH_W], td4_q[c*CH_W +: CH_W], fx4_q);
    end
  end

  logic [TEXEL_W-1:0]   top5_q, bot5_q;
  logic [FRAC_BITS-1:0] fy5_q;

  always_ff @(posedge clk_i) begin
    if (en5) begin
      top5_q <= top_d;
      bot5_q <= bot_d;
      fy5_q  <= fy4_q;
    end
  end

  // stage 6: blend along y, output register
  logic [TEXEL_W-1:0] out_d, out6_q;

  always_comb begin
    for (int c = 0; c < N_CH; c++) begin
      out_d[c*CH_W +: CH_W] = lerp(top5_q[c*CH_W +: CH_W], bot5_q[c*CH_W +: CH_W], fy5_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en6) out6_q <= out_d;
  end

  assign rsp_o.valid         = v6_q;
  assign rsp_o.sampled_texel = out6_q;

endmodule

>>> rtl/core/bts_checker.sv
`include "assert_macros.svh"

module bts_checker import bts_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               req_valid_i,
  input logic               req_ready_i,
  input logic               req_mode_i,
  input logic               rsp_valid_i,
  input logic               rsp_ready_i,
  input logic [TEXEL_W-1:0] rsp_texel_i
);

  localparam logic [3:0] PIPE_DEPTH = 4'd6;

  logic [3:0] pend_q, pend_d;
  logic       smp_in, smp_out;

  assign smp_in  = req_valid_i && req_ready_i && (req_mode_i == MODE_SAMPLE);
  assign smp_out = rsp_valid_i && rsp_ready_i;
  assign pend_d  = pend_q + {3'd0, smp_in} - {3'd0, smp_out};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  `ASSERT_ALWAYS(a_rst_no_result, clk_i, !rst_ni |=> !rsp_valid_i)
  `ASSERT_CLK(a_result_held, clk_i, rst_ni,
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_texel_i))
  `ASSERT_CLK(a_empty_takes_item, clk_i, rst_ni, !rsp_valid_i |-> req_ready_i)
  `ASSERT_CLK(a_result_has_sample, clk_i, rst_ni, rsp_valid_i |-> pend_q != 4'd0)
  `ASSERT_CLK(a_pend_bounded, clk_i, rst_ni, pend_q <= PIPE_DEPTH)

endmodule

bind bilinear_rgba8_texel_sampler bts_checker u_bts_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .req_mode_i  (req_i.mode),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_texel_i (rsp_o.sampled_texel)
);
